>>> rtl/b64e_pkg.sv
`timescale 1ns / 1ps

package b64e_pkg;

   localparam int CharWidth = 8;
   localparam int MaxChars = 4;

   typedef logic [CharWidth-1:0] char_type;
   typedef logic [5:0] sextet_type;
   typedef logic [1:0] csr_index_type;
   typedef logic [1:0] char_index_type;
   typedef logic [2:0] char_count_type;

   localparam csr_index_type CSR_SYMBOL_62 = 2'd0;
   localparam csr_index_type CSR_SYMBOL_63 = 2'd1;
   localparam csr_index_type CSR_PAD = 2'd2;

   localparam char_type SYMBOL_62_RESET = 8'd43;
   localparam char_type SYMBOL_63_RESET = 8'd47;
   localparam char_type PAD_RESET = 8'd61;

   // Characters produced by one input byte, oldest in entry zero.
   typedef struct packed {
      char_type [MaxChars-1:0] chars;
      char_count_type count;
      logic last;
   } group_type;

   function automatic char_type symbol_char(input sextet_type value,
                                            input char_type sym62,
                                            input char_type sym63);
      char_type result;
      case (value) inside
         [6'd0:6'd25]: begin
            result = 8'h41 + {2'b00, value};
         end
         [6'd26:6'd51]: begin
            result = 8'h47 + {2'b00, value};
         end
         [6'd52:6'd61]: begin
            result = {2'b00, value} - 8'd4;
         end
         6'd62: begin
            result = sym62;
         end
         default: begin
            result = sym63;
         end
      endcase
      return result;
   endfunction

endpackage

>>> rtl/b64e_req_if.sv
`timescale 1ns / 1ps

interface b64e_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

>>> rtl/b64e_rsp_if.sv
`timescale 1ns / 1ps

interface b64e_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_char;
   logic out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink (input valid, input out_char, input out_last, output ready);
endinterface

>>> rtl/b64e_serializer.sv
`timescale 1ns / 1ps

module b64e_serializer (
   input logic clock,
   input logic reset,
   input logic load,
   input b64e_pkg::group_type group_in,
   output logic can_load,
   b64e_rsp_if.source rsp_channel
);
   import b64e_pkg::*;

   group_type grp_ff;
   logic grp_valid_ff;
   char_index_type idx_ff;
   char_type char_ff;
   logic last_ff;
   logic valid_ff;

   logic out_free;
   logic move;
   logic final_move;

   assign out_free = !valid_ff || rsp_channel.ready;
   assign move = grp_valid_ff && out_free;
   assign final_move = move && (({1'b0, idx_ff} + 3'd1) == grp_ff.count);
   assign can_load = !grp_valid_ff || final_move;

   assign rsp_channel.valid = valid_ff;
   assign rsp_channel.out_char = char_ff;
   assign rsp_channel.out_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            grp_valid_ff <= 1'b1;
            idx_ff <= '0;
         end else if (final_move) begin
            grp_valid_ff <= 1'b0;
         end else if (move) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (move) begin
            valid_ff <= 1'b1;
         end else if (rsp_channel.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= group_in;
      end
      if (move) begin
         char_ff <= grp_ff.chars[idx_ff];
         last_ff <= final_move && grp_ff.last;
      end
   end

endmodule

>>> rtl/base64_encoder_core.sv
`timescale 1ns / 1ps

// Streaming base64 encoder. Each accepted transaction carries one message byte and a
// last-byte flag; the encoder emits the one to four characters that byte completes,
// one character per response transaction, with out_last marking the final character
// of the message. Padding uses pad_ff and is turned off by writing zero to it.
// A byte is encoded in the cycle it is accepted, and the output stage then sends
// one character per cycle while the response channel is ready. The next byte is
// accepted in the cycle its predecessor's last character moves to the output
// register. Configuration is written only while idle: the user must keep to this,
// as the block itself does not enforce it.
module base64_encoder_core (
   input logic clock,
   input logic reset,
   b64e_req_if.sink req_channel,
   b64e_rsp_if.source rsp_channel,
   input logic csr_write_en,
   input b64e_pkg::csr_index_type csr_index,
   input b64e_pkg::char_type csr_write_data
);
   import b64e_pkg::*;

   char_type sym62_ff;
   char_type sym63_ff;
   char_type pad_ff;
   logic [1:0] pos_ff;
   logic [3:0] carry_ff;
   logic [1:0] pos_in;
   logic [3:0] carry_in;

   logic accept;
   logic can_load;
   logic pad_on;
   logic [7:0] b;
   sextet_type s0;
   sextet_type s1;
   group_type group;

   assign accept = req_channel.valid && req_channel.ready;
   assign req_channel.ready = can_load;
   assign pad_on = (pad_ff != 8'd0);
   assign b = req_channel.data_byte;

   always_comb begin
      s0 = '0;
      s1 = '0;
      group.count = 3'd1;
      pos_in = pos_ff;
      carry_in = carry_ff;
      case (pos_ff)
         2'd0: begin
            s0 = b[7:2];
            s1 = {b[1:0], 4'b0000};
            pos_in = 2'd1;
            carry_in = {2'b00, b[1:0]};
            if (req_channel.is_last) begin
               group.count = pad_on ? 3'd4 : 3'd2;
            end
         end
         2'd1: begin
            s0 = {carry_ff[1:0], b[7:4]};
            s1 = {b[3:0], 2'b00};
            pos_in = 2'd2;
            carry_in = b[3:0];
            if (req_channel.is_last) begin
               group.count = pad_on ? 3'd3 : 3'd2;
            end
         end
         default: begin
            s0 = {carry_ff[3:0], b[7:6]};
            s1 = b[5:0];
            pos_in = 2'd0;
            carry_in = 4'd0;
            group.count = 3'd2;
         end
      endcase
      if (req_channel.is_last) begin
         pos_in = 2'd0;
         carry_in = 4'd0;
      end
      group.chars[0] = symbol_char(s0, sym62_ff, sym63_ff);
      group.chars[1] = symbol_char(s1, sym62_ff, sym63_ff);
      group.chars[2] = pad_ff;
      group.chars[3] = pad_ff;
      group.last = req_channel.is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym62_ff <= SYMBOL_62_RESET;
         sym63_ff <= SYMBOL_63_RESET;
         pad_ff <= PAD_RESET;
         pos_ff <= 2'd0;
         carry_ff <= 4'd0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SYMBOL_62: sym62_ff <= csr_write_data;
               CSR_SYMBOL_63: sym63_ff <= csr_write_data;
               CSR_PAD: pad_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (accept) begin
            pos_ff <= pos_in;
            carry_ff <= carry_in;
         end
      end
   end

   b64e_serializer u_serializer (
      .clock(clock),
      .reset(reset),
      .load(accept),
      .group_in(group),
      .can_load(can_load),
      .rsp_channel(rsp_channel)
   );

endmodule
